// ===== design/mst_pkg.sv =====
// Shared types, codes and field widths for the min-tracking stack.
package mst_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // in tdata: command, push_value; padded to whole bytes
    localparam int IN_BITS  = CMD_W + WORD_W;
    localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
    // out tdata: popped, status, top, min, empty, full
    localparam int OUT_BITS = 3 * WORD_W + STAT_W + 2;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        t_word             popped;
        logic [STAT_W-1:0] status;
        t_word             top;
        t_word             min;
        logic              empty;
        logic              full;
    } t_result;

endpackage

// ===== design/mst_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module mst_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  mst_pkg::t_word    i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output mst_pkg::t_word    o_rd_data
);
    import mst_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mst_ctrl.sv =====
// Sequencer: command decode, cached top/min, counts, capacity and result register.
module mst_ctrl #(
    parameter int MAX_DEPTH = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [mst_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mst_pkg::CMD_W-1:0]   i_command,
    input  mst_pkg::t_word              i_push_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mst_pkg::t_result            o_result,
    output logic                        o_vwr_en,
    output logic                        o_mwr_en,
    output logic [AW-1:0]               o_vwr_addr,
    output logic [AW-1:0]               o_mwr_addr,
    output mst_pkg::t_word              o_wr_data,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_vrd_addr,
    output logic [AW-1:0]               o_mrd_addr,
    input  mst_pkg::t_word              i_vrd_data,
    input  mst_pkg::t_word              i_mrd_data
);
    import mst_pkg::*;

    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CMD_W-1:0] r_cmd;
    t_word            r_val;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_mcount, n_mcount;
    t_word            r_top, n_top;
    t_word            r_min, n_min;
    logic [CAP_W-1:0] r_cap;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic [CMPW-1:0]  eff_cap;
    logic             out_free;
    logic             is_full_now;
    logic             min_hit;
    logic             push_min;

    always_comb begin
        eff_cap = CMPW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CMPW'(1);
        end else if (eff_cap > CMPW'(MAX_DEPTH)) begin
            eff_cap = CMPW'(MAX_DEPTH);
        end
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign is_full_now = CMPW'(r_count) >= eff_cap;
    assign min_hit     = (r_mcount != '0) && (r_top == r_min);
    assign push_min    = (r_mcount == '0) || (r_val <= r_min);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // next top sits one below the current top in both stacks
    assign o_rd_en    = (r_state == ST_EXEC) && (r_cmd == CMD_POP);
    assign o_vrd_addr = AW'(r_count - CW'(2));
    assign o_mrd_addr = AW'(r_mcount - CW'(2));
    assign o_vwr_addr = r_count[AW-1:0];
    assign o_mwr_addr = r_mcount[AW-1:0];
    assign o_wr_data  = r_val;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mcount    = r_mcount;
        n_top       = r_top;
        n_min       = r_min;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_vwr_en    = 1'b0;
        o_mwr_en    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_cmd == CMD_POP && r_count != '0) begin
                    n_state = ST_FETCH;
                end else if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out.popped = '0;
                    n_out.status = STAT_OK;
                    if (r_cmd == CMD_PUSH) begin
                        if (is_full_now) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            o_vwr_en = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_top    = r_val;
                            if (push_min) begin
                                o_mwr_en = 1'b1;
                                n_mcount = r_mcount + CW'(1);
                                n_min    = r_val;
                            end
                        end
                    end else if (r_cmd == CMD_POP) begin
                        n_out.status = STAT_EMPTY;
                    end
                    n_out.top   = (n_count != '0) ? n_top : '0;
                    n_out.min   = (n_count != '0) ? n_min : '0;
                    n_out.empty = (n_count == '0);
                    n_out.full  = CMPW'(n_count) >= eff_cap;
                end
            end
            ST_FETCH: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_count     = r_count - CW'(1);
                    n_top       = (n_count != '0) ? i_vrd_data : '0;
                    if (min_hit) begin
                        n_mcount = r_mcount - CW'(1);
                        n_min    = (n_mcount != '0) ? i_mrd_data : '0;
                    end
                    n_out.popped = r_top;
                    n_out.status = STAT_OK;
                    n_out.top    = n_top;
                    n_out.min    = (n_count != '0) ? n_min : '0;
                    n_out.empty  = (n_count == '0);
                    n_out.full   = CMPW'(n_count) >= eff_cap;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_mcount    <= '0;
            r_top       <= '0;
            r_min       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mcount    <= n_mcount;
            r_top       <= n_top;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_cmd <= i_command;
            r_val <= i_push_value;
        end
    end

endmodule

// ===== design/min_tracking_stack_top.sv =====
// Min-tracking stack: bounded LIFO of signed words with running minimum.
//
// Input stream (s side): one command per transaction, push, pop or query.
//   Command code 3 acts as a query. Ready is high only while idle, so one
//   command is in flight at a time.
// Output stream (m side): exactly one result per command: popped value,
//   status, new top, new minimum, empty and full flags.
// Config: i_cfg_wen/i_cfg_wdata write the capacity (0 acts as 1, values
//   above MAX_DEPTH act as MAX_DEPTH). Write only while idle.
// Timing: with the output free, a push or query result is registered as
//   the sequencer leaves EXEC, and a pop result on a non-empty stack as it
//   leaves FETCH, after EXEC, since the entry below the top comes out of a
//   registered RAM read. Ready returns with the result, so a new command is
//   accepted only once the previous result is registered. The top and minimum
//   are cached in registers; both stacks live in RAMs with one write and one read port.
// Reset: counts cleared, capacity back to 64, output invalid. RAM contents
//   are not cleared; entries are only read after being written.
// Stall: a result waits in the output register while the next command can
//   be accepted; that command then waits before committing until the
//   output register frees up.
module min_tracking_stack_top #(
    parameter int MAX_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [mst_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [1:0] command, [33:2] push_value, rest zero
    input  logic [mst_pkg::IN_TW-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] popped_value, [33:32] status, [65:34] top_value,
    // [97:66] min_value, [98] is_empty, [99] is_full, rest zero
    output logic [mst_pkg::OUT_TW-1:0]    o_m_tdata
);
    import mst_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = $clog2(MAX_DEPTH + 1);

    t_result          res;
    logic             vwr_en, mwr_en, rd_en;
    logic [AW-1:0]    vwr_addr, mwr_addr, vrd_addr, mrd_addr;
    t_word            wr_data, vrd_data, mrd_data;

    mst_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_command    (i_s_tdata[CMD_W-1:0]),
        .i_push_value (i_s_tdata[CMD_W+WORD_W-1:CMD_W]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_result     (res),
        .o_vwr_en     (vwr_en),
        .o_mwr_en     (mwr_en),
        .o_vwr_addr   (vwr_addr),
        .o_mwr_addr   (mwr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_vrd_addr   (vrd_addr),
        .o_mrd_addr   (mrd_addr),
        .i_vrd_data   (vrd_data),
        .i_mrd_data   (mrd_data)
    );

    mst_ram #(.DEPTH(MAX_DEPTH), .AW(AW)) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vwr_en),
        .i_wr_addr (vwr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (vrd_addr),
        .o_rd_data (vrd_data)
    );

    mst_ram #(.DEPTH(MAX_DEPTH), .AW(AW)) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mwr_en),
        .i_wr_addr (mwr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (mrd_addr),
        .o_rd_data (mrd_data)
    );

    assign o_m_tdata = OUT_TW'({res.full, res.empty, res.min, res.top,
                                res.status, res.popped});

endmodule

// ===== design/mst_checker.sv =====
// Port-level checks for the min-tracking stack, bound to the top level.
module mst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [103:0] o_m_tdata
);

    // one command in flight: ready drops right after a transaction
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while a command is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

    // an empty stack reports zero top and minimum and is never full
    // (effective capacity is at least one)
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[98] |->
            o_m_tdata[65:34] == 32'd0 && o_m_tdata[97:66] == 32'd0 && !o_m_tdata[99])
        else $error("empty result with nonzero top/min or full flag");

    // pop on empty returns zero and leaves the stack empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[33:32] == 2'd2 |->
            o_m_tdata[31:0] == 32'd0 && o_m_tdata[98])
        else $error("pop-on-empty result inconsistent");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind min_tracking_stack_top mst_checker u_mst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
